@@ rtl/core/bccwe_pkg.sv @@
package bccwe_pkg;

  localparam int NumDigits = 6;
  localparam int DigitW    = 4;
  localparam int SelW      = 3;
  localparam int PrescW    = 8;
  localparam int SegW      = 8;

  localparam logic [PrescW-1:0] TicksPerSecReset = 8'd60;

  // Action codes carried by the input channel
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_INCR   = 2'd2
  } action_t;

  typedef logic [DigitW-1:0] digit_t;

  // Carry limits for seconds units up to hours units
  localparam digit_t DigitLimit [NumDigits-1] = '{
    4'd10, 4'd6, 4'd10, 4'd6, 4'd10
  };

  localparam digit_t HoursTensLimit = 4'd10;
  localparam digit_t DigitMax       = 4'd9;
  localparam digit_t DigitMod       = 4'd10;
  localparam logic [SelW-1:0] SelLast = 3'd5;
  localparam logic [NumDigits-1:0] PosEnableTop = 6'h20;

  // Active-low seven-segment code for one decimal digit
  function automatic logic [SegW-1:0] seg_code(input digit_t val);
    logic [SegW-1:0] code;
    case (val)
      4'd0:    code = 8'h40;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'h24;
      4'd3:    code = 8'h30;
      4'd4:    code = 8'h19;
      4'd5:    code = 8'h12;
      4'd6:    code = 8'h02;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h00;
      4'd9:    code = 8'h10;
      default: code = 8'h40;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/bccwe_if.sv @@
interface bccwe_in_if;
  import bccwe_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       count_hold;

  modport source (output valid, output action, output count_hold, input ready);
  modport sink   (input valid, input action, input count_hold, output ready);
endinterface

interface bccwe_out_if;
  import bccwe_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DigitW-1:0]    seconds_units;
  logic [DigitW-1:0]    seconds_tens;
  logic [DigitW-1:0]    minutes_units;
  logic [DigitW-1:0]    minutes_tens;
  logic [DigitW-1:0]    hours_units;
  logic [DigitW-1:0]    hours_tens;
  logic [NumDigits-1:0] position_enable;
  logic [SegW-1:0]      segment_pattern;

  modport source (
    output valid, output seconds_units, output seconds_tens, output minutes_units,
    output minutes_tens, output hours_units, output hours_tens,
    output position_enable, output segment_pattern, input ready
  );
  modport sink (
    input valid, input seconds_units, input seconds_tens, input minutes_units,
    input minutes_tens, input hours_units, input hours_tens,
    input position_enable, input segment_pattern, output ready
  );
endinterface

@@ rtl/core/bcd_clock_counter_with_edit_unit.sv @@
// Channel   Dir  Payload                                         Handshake
// in_ch     in   action[1:0], count_hold                         valid/ready
// out_ch    out  six BCD digits, position_enable, segment_pattern valid/ready
// cfg       in   cfg_wdata[7:0] = ticks per second               cfg_we, no wait
//
// One action per cycle while the output is not stalled: the state and the
// output register both update at the edge that takes the transfer.
// The output register is the only stage; a new action is taken whenever it is
// empty or being drained in the same cycle, so back-to-back throughput is one.
// Reset (synchronous, rst_n low) clears the time to 00:00:00, the cursor to
// seconds units, the prescaler to zero and sets ticks per second to 60.
module bcd_clock_counter_with_edit_unit (
  input  logic               clk,
  input  logic               rst_n,
  bccwe_in_if.sink           in_ch,
  bccwe_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import bccwe_pkg::*;

  logic [PrescW-1:0]  tps_r;
  logic [PrescW-1:0]  presc_r, presc_nxt;
  digit_t             digits_r   [NumDigits];
  digit_t             digits_nxt [NumDigits];
  logic [SelW-1:0]    sel_r, sel_nxt;
  logic               out_valid_r;
  digit_t             out_digits_r [NumDigits];
  logic [NumDigits-1:0] pos_en_r;
  logic [SegW-1:0]    seg_r;

  logic               in_xfer;
  logic [SelW-1:0]    sel_cur;
  logic [PrescW:0]    presc_inc;
  digit_t             sel_digit;
  digit_t             sel_digit_dec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Next state for one action
  always_comb begin
    logic   carry;
    digit_t bumped;
    presc_nxt  = presc_r;
    digits_nxt = digits_r;
    sel_cur    = (sel_r > SelLast) ? '0 : sel_r;
    sel_nxt    = sel_cur;
    presc_inc  = {1'b0, presc_r} + 9'd1;
    carry      = 1'b0;
    bumped     = '0;
    case (in_ch.action)
      ACT_TICK: begin
        if (!in_ch.count_hold) begin
          if (presc_inc >= {1'b0, tps_r}) begin
            presc_nxt = '0;
            carry     = 1'b1;
          end else begin
            presc_nxt = presc_inc[PrescW-1:0];
          end
          // Ripple the seconds advance through the digits
          for (int k = 0; k < NumDigits - 1; k++) begin
            if (carry) begin
              bumped = digits_r[k] + 4'd1;
              if (bumped >= DigitLimit[k]) begin
                digits_nxt[k] = '0;
              end else begin
                digits_nxt[k] = bumped;
                carry         = 1'b0;
              end
            end
          end
          if (carry) begin
            bumped = digits_r[NumDigits-1] + 4'd1;
            digits_nxt[NumDigits-1] = (bumped >= HoursTensLimit) ? '0 : bumped;
          end
          // Drop twelve o'clock to midnight
          if (digits_nxt[5] == 4'd1 && digits_nxt[4] == 4'd2) begin
            for (int k = 0; k < NumDigits; k++) digits_nxt[k] = '0;
          end
        end
      end
      ACT_SELECT: begin
        sel_nxt = (sel_cur >= SelLast) ? '0 : sel_cur + 3'd1;
      end
      ACT_INCR: begin
        digits_nxt[sel_cur] = (digits_r[sel_cur] >= DigitMax) ? '0
                              : digits_r[sel_cur] + 4'd1;
      end
      default: ;
    endcase
  end

  // Segment code of the digit under the cursor after the action
  assign sel_digit     = digits_nxt[sel_nxt];
  assign sel_digit_dec = (sel_digit >= DigitMod) ? sel_digit - DigitMod : sel_digit;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TicksPerSecReset;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  // Advance clock state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= '0;
      sel_r   <= '0;
      for (int k = 0; k < NumDigits; k++) digits_r[k] <= '0;
    end else if (in_xfer) begin
      presc_r  <= presc_nxt;
      sel_r    <= sel_nxt;
      digits_r <= digits_nxt;
    end
  end

  // Output register: load on input transfer, drop when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_digits_r <= digits_nxt;
      pos_en_r     <= PosEnableTop >> sel_nxt;
      seg_r        <= seg_code(sel_digit_dec);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.seconds_units   = out_digits_r[0];
  assign out_ch.seconds_tens    = out_digits_r[1];
  assign out_ch.minutes_units   = out_digits_r[2];
  assign out_ch.minutes_tens    = out_digits_r[3];
  assign out_ch.hours_units     = out_digits_r[4];
  assign out_ch.hours_tens      = out_digits_r[5];
  assign out_ch.position_enable = pos_en_r;
  assign out_ch.segment_pattern = seg_r;

endmodule

@@ verif/bcd_clock_counter_with_edit_unit_tb.sv @@
module bcd_clock_counter_with_edit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bccwe_pkg::*;

  // Action code the block must ignore while still producing a result
  localparam logic [1:0] ActUnknown = 2'd3;

  localparam int CycleLimit  = 200000;
  localparam int LongHold    = 60;
  localparam int RandomItems = 360;
  localparam int NumPhases   = 6;

  // Active-low seven-segment codes, digits 0 to 9
  localparam logic [SegW-1:0] SegLut [10] = '{
    8'h40, 8'hF9, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'hF8, 8'h00, 8'h10
  };
  // Carry thresholds from seconds units up to hours units
  localparam int CarryAt [NumDigits-1] = '{10, 6, 10, 6, 10};
  localparam logic [NumDigits-1:0] LeftmostPos = 6'h20;

  typedef struct packed {
    digit_t               seconds_units;
    digit_t               seconds_tens;
    digit_t               minutes_units;
    digit_t               minutes_tens;
    digit_t               hours_units;
    digit_t               hours_tens;
    logic [NumDigits-1:0] position_enable;
    logic [SegW-1:0]      segment_pattern;
  } clock_view_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  bccwe_in_if  in_bus ();
  bccwe_out_if out_bus ();

  bcd_clock_counter_with_edit_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted clock state
  logic [PrescW-1:0] ticks_per_sec;
  logic [PrescW-1:0] prescale_ticks;
  digit_t            clock_digits [NumDigits];
  logic [SelW-1:0]   edit_cursor;

  clock_view_t pending_views [$];
  int          mismatch_count = 0;
  int          sent_items = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          long_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clock state model

  function automatic void reset_clock_model();
    ticks_per_sec  = TicksPerSecReset;
    prescale_ticks = '0;
    foreach (clock_digits[k]) clock_digits[k] = '0;
    edit_cursor    = '0;
  endfunction

  // Ripple one second through the digits; hours tens wraps at ten
  function automatic void advance_time();
    bit carry;
    carry = 1'b1;
    for (int k = 0; k < NumDigits - 1; k++) begin
      if (carry) begin
        clock_digits[k] = clock_digits[k] + 1'b1;
        if (clock_digits[k] >= CarryAt[k]) begin
          clock_digits[k] = '0;
        end else begin
          carry = 1'b0;
        end
      end
    end
    if (carry) begin
      clock_digits[5] = clock_digits[5] + 1'b1;
      if (clock_digits[5] >= 4'd10) clock_digits[5] = '0;
    end
  endfunction

  function automatic void count_tick();
    logic [PrescW:0] next_count;
    next_count = {1'b0, prescale_ticks} + 1'b1;
    if (next_count >= {1'b0, ticks_per_sec}) begin
      prescale_ticks = '0;
      advance_time();
    end else begin
      prescale_ticks = next_count[PrescW-1:0];
    end
    // Twelve o'clock reads as zero, checked on every counting tick
    if (clock_digits[5] == 4'd1 && clock_digits[4] == 4'd2) begin
      foreach (clock_digits[k]) clock_digits[k] = '0;
    end
  endfunction

  function automatic clock_view_t current_view();
    clock_view_t view;
    view.seconds_units   = clock_digits[0];
    view.seconds_tens    = clock_digits[1];
    view.minutes_units   = clock_digits[2];
    view.minutes_tens    = clock_digits[3];
    view.hours_units     = clock_digits[4];
    view.hours_tens      = clock_digits[5];
    view.position_enable = LeftmostPos >> edit_cursor;
    view.segment_pattern = SegLut[clock_digits[edit_cursor] % 10];
    return view;
  endfunction

  // Apply one accepted action and queue the display it should produce
  function automatic void apply_action(logic [1:0] act, logic edit);
    if (edit_cursor >= NumDigits) edit_cursor = '0;
    case (act)
      ACT_TICK: begin
        if (!edit) count_tick();
      end
      ACT_SELECT: begin
        edit_cursor = (edit_cursor >= SelLast) ? '0 : edit_cursor + 1'b1;
      end
      ACT_INCR: begin
        clock_digits[edit_cursor] = (clock_digits[edit_cursor] >= DigitMax) ? '0
                                    : clock_digits[edit_cursor] + 1'b1;
      end
      default: ;
    endcase
    pending_views.push_back(current_view());
  endfunction

  // Driver side

  task automatic send_action(input logic [1:0] act, input logic edit);
    if (idle_on && $urandom_range(0, 99) < 6) begin
      in_bus.valid      <= 1'b0;
      in_bus.action     <= 2'($urandom_range(0, 3));
      in_bus.count_hold <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.action     <= act;
    in_bus.count_hold <= edit;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    apply_action(act, edit);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic set_tick_rate(input logic [7:0] rate);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we        <= 1'b0;
    ticks_per_sec = rate;
  endtask

  // Move the cursor to a digit and increment it up to the wanted value
  task automatic set_digit(input int idx, input digit_t value, input logic edit);
    while (edit_cursor != idx) send_action(ACT_SELECT, edit);
    while (clock_digits[idx] != value) send_action(ACT_INCR, edit);
  endtask

  task automatic set_time(input digit_t ht, input digit_t hu, input digit_t mt,
                          input digit_t mu, input digit_t st, input digit_t su);
    set_digit(0, su, 1'($urandom_range(0, 1)));
    set_digit(1, st, 1'($urandom_range(0, 1)));
    set_digit(2, mu, 1'($urandom_range(0, 1)));
    set_digit(3, mt, 1'($urandom_range(0, 1)));
    set_digit(4, hu, 1'($urandom_range(0, 1)));
    set_digit(5, ht, 1'($urandom_range(0, 1)));
  endtask

  // Favor values just below a carry so the chain gets exercised
  function automatic digit_t near_carry_value(int idx);
    if ($urandom_range(0, 1)) return (idx == 1 || idx == 3) ? 4'd5 : 4'd9;
    return digit_t'($urandom_range(0, 9));
  endfunction

  // Tests

  task automatic test_idle_and_unknown();
    // Counting ticks at the reset rate only move the prescaler
    send_action(ACT_TICK, 1'b0);
    send_action(ACT_TICK, 1'b0);
    // Held ticks and the unused code leave the state alone
    send_action(ACT_TICK, 1'b1);
    send_action(ActUnknown, 1'b0);
    send_action(ActUnknown, 1'b1);
    // Bump every digit while walking the cursor past the last and back
    repeat (NumDigits + 1) begin
      send_action(ACT_INCR, 1'b1);
      send_action(ACT_SELECT, 1'b0);
    end
  endtask

  task automatic test_rate_extremes();
    // Zero rate acts like one: every counting tick advances
    set_tick_rate(8'd0);
    repeat (2) send_action(ACT_TICK, 1'b0);
    set_tick_rate(8'd255);
    repeat (3) send_action(ACT_TICK, 1'b0);
    set_tick_rate(8'd1);
    repeat (2) send_action(ACT_TICK, 1'b0);
  endtask

  task automatic test_rollovers();
    digit_t hour_tens [4];
    digit_t hour_units [4];
    hour_tens  = '{4'd1, 4'd0, 4'd9, 4'd1};
    hour_units = '{4'd1, 4'd9, 4'd9, 4'd9};
    // One second before twelve, ten, hours tens wrap and twenty
    for (int k = 0; k < 4; k++) begin
      set_time(hour_tens[k], hour_units[k], 4'd5, 4'd9, 4'd5, 4'd9);
      send_action(ACT_TICK, 1'b1);
      send_action(ACT_TICK, 1'b0);
    end
    // An edited twelve stays until a counting tick that does not advance
    set_tick_rate(8'd255);
    set_time(4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6);
    send_action(ACT_TICK, 1'b1);
    send_action(ACT_TICK, 1'b0);
  endtask

  task automatic test_backpressure();
    // Stall the output long enough for the input to back up
    long_hold_req = 1'b1;
    repeat (12) send_action(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_traffic();
    logic [7:0] phase_rates [NumPhases];
    int         phase_end;
    int         pick;
    int         idx;
    digit_t     ht;
    digit_t     hu;
    phase_rates = '{8'd1, 8'd0, 8'd3, 8'd255, 8'($urandom_range(2, 7)), 8'd1};
    for (int p = 0; p < NumPhases; p++) begin
      set_tick_rate(phase_rates[p]);
      idle_on   = (p != 2);
      phase_end = sent_items + RandomItems / NumPhases;
      while (sent_items < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // Edit the time, then let it run
          if (pick < 20) begin
            case ($urandom_range(0, 2))
              0:       ht = 4'd0;
              1:       ht = 4'd1;
              default: ht = 4'd9;
            endcase
            case ($urandom_range(0, 2))
              0:       hu = 4'd1;
              1:       hu = 4'd2;
              default: hu = 4'd9;
            endcase
            set_time(ht, hu, 4'd5, 4'd9, 4'd5, 4'd9);
          end else begin
            repeat ($urandom_range(1, 3)) begin
              idx = $urandom_range(0, NumDigits - 1);
              set_digit(idx, near_carry_value(idx), 1'($urandom_range(0, 1)));
            end
          end
          repeat ($urandom_range(1, 30)) begin
            send_action(ACT_TICK, 1'($urandom_range(0, 9) == 0));
          end
        end else begin
          // Noise: any code, any edit flag
          repeat ($urandom_range(1, 8)) begin
            send_action(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
          end
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Result side

  initial begin : result_sink
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        out_bus.ready <= !(idle_on && $urandom_range(0, 99) < 6);
      end
    end
  end

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each transfer against the oldest predicted display
  always @(posedge clk) begin : result_check
    clock_view_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_views.size() == 0) begin
        $error("result transfer with no prediction pending");
        mismatch_count++;
      end else begin
        want = pending_views.pop_front();
        check_field("seconds_units", want.seconds_units, out_bus.seconds_units);
        check_field("seconds_tens", want.seconds_tens, out_bus.seconds_tens);
        check_field("minutes_units", want.minutes_units, out_bus.minutes_units);
        check_field("minutes_tens", want.minutes_tens, out_bus.minutes_tens);
        check_field("hours_units", want.hours_units, out_bus.hours_units);
        check_field("hours_tens", want.hours_tens, out_bus.hours_tens);
        check_field("position_enable", want.position_enable, out_bus.position_enable);
        check_field("segment_pattern", want.segment_pattern, out_bus.segment_pattern);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Test sequence
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_TICK;
    in_bus.count_hold = 1'b0;
    reset_clock_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_and_unknown();
    test_rate_extremes();
    test_rollovers();
    test_backpressure();
    test_random_traffic();

    // Drain, then watch for any stray transfer
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
